/* src/assert_macros.svh */
// shared assertion macros, used inside modules that have clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ZUP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ZUP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/zup_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package zup_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int ID_BYTES    = 4;

  typedef enum logic [1:0] {
    KIND_UNKNOWN,
    KIND_OLD,
    KIND_SECOND,
    KIND_NEW
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_VERSION,
    ST_OVERFLOW,
    ST_UNKNOWN
  } status_t;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      kind;
    logic       first_item;
    logic       last_item;
    logic       no_data;
  } entry_t;

endpackage

`default_nettype wire

/* src/zup_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface zup_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] field_tag;
  logic        first_item;
  logic        last_item;
  logic        no_data;

  modport source (
    output valid, data_byte, field_tag, first_item, last_item, no_data,
    input  ready
  );
  modport sink (
    input  valid, data_byte, field_tag, first_item, last_item, no_data,
    output ready
  );
endinterface

interface zup_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        has_times;
  logic [31:0] access_time;
  logic [31:0] modify_time;
  logic [31:0] user_id;
  logic [31:0] group_id;

  modport source (
    output valid, status, has_times, access_time, modify_time, user_id, group_id,
    input  ready
  );
  modport sink (
    input  valid, status, has_times, access_time, modify_time, user_id, group_id,
    output ready
  );
endinterface

`default_nettype wire

/* src/zup_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module zup_front (
  zup_in_if.sink            in_bus,
  input  logic              q_full,
  output logic              push,
  output zup_pkg::entry_t   push_ent
);

  localparam logic [15:0] TAG_OLD_A  = 16'h000D;
  localparam logic [15:0] TAG_OLD_B  = 16'h5855;
  localparam logic [15:0] TAG_SECOND = 16'h7855;
  localparam logic [15:0] TAG_NEW    = 16'h7875;

  zup_pkg::kind_t kind;

  // header id decode
  always_comb begin
    if (in_bus.field_tag == TAG_OLD_A || in_bus.field_tag == TAG_OLD_B) begin
      kind = zup_pkg::KIND_OLD;
    end else if (in_bus.field_tag == TAG_SECOND) begin
      kind = zup_pkg::KIND_SECOND;
    end else if (in_bus.field_tag == TAG_NEW) begin
      kind = zup_pkg::KIND_NEW;
    end else begin
      kind = zup_pkg::KIND_UNKNOWN;
    end
  end

  assign in_bus.ready        = !q_full;
  assign push                = in_bus.valid && !q_full;
  assign push_ent.data_byte  = in_bus.data_byte;
  assign push_ent.kind       = kind;
  assign push_ent.first_item = in_bus.first_item;
  assign push_ent.last_item  = in_bus.last_item;
  assign push_ent.no_data    = in_bus.no_data;

endmodule

`default_nettype wire

/* src/zup_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module zup_fifo #(
  parameter int DEPTH = zup_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  zup_pkg::entry_t   push_ent,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output zup_pkg::entry_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  zup_pkg::entry_t    mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_ent;
    end
  end

  `ZUP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count past depth")
  `ZUP_ASSERT_NXT(a_push_fill, push && !pop, cnt_r != '0, "queue empty after push")
  `ZUP_ASSERT_NXT(a_pop_drain, pop && !push, cnt_r == CNT_W'($past(cnt_r) - 1'b1),
    "queue count wrong after pop")

endmodule

`default_nettype wire

/* src/zup_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module zup_back #(
  parameter int ID_BYTES = zup_pkg::ID_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  zup_pkg::entry_t   head,
  output logic              pop,
  zup_out_if.source         out_bus
);

  localparam logic [3:0]  OLD_LEN     = 4'd12;
  localparam logic [3:0]  SECOND_LEN  = 4'd4;
  localparam logic [7:0]  NEW_VERSION = 8'd1;

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_ULEN,
    PH_UBYTES,
    PH_GLEN,
    PH_GBYTES,
    PH_DONE,
    PH_STOP
  } phase_t;

  typedef struct packed {
    zup_pkg::kind_t   kind;
    logic [3:0]       pos;
    phase_t           phase;
    logic [7:0]       id_len;
    logic [7:0]       id_cnt;
    zup_pkg::status_t err;
    logic [31:0]      acc_at;
    logic [31:0]      acc_mt;
    logic [31:0]      acc_uid;
    logic [31:0]      acc_gid;
  } parse_t;

  parse_t           st_r, st_nxt, st_b, st_w;
  zup_pkg::status_t status_w;
  logic             out_free, done;
  logic [7:0]       b;

  logic             out_valid_r, out_valid_nxt;
  zup_pkg::status_t status_r;
  logic             has_times_r;
  logic [31:0]      at_r, mt_r, uid_r, gid_r;

  assign out_free = !out_valid_r || out_bus.ready;
  assign pop      = head_valid && (!head.last_item || out_free);
  assign done     = pop && head.last_item;
  assign b        = head.data_byte;

  // state after this byte
  always_comb begin
    if (head.first_item) begin
      st_b      = '0;
      st_b.kind = head.kind;
    end else begin
      st_b = st_r;
    end
    st_w = st_b;
    if (!head.no_data) begin
      case (st_b.kind)
        zup_pkg::KIND_OLD: begin
          if (st_b.pos < 4'd4) begin
            st_w.acc_at[{st_b.pos[1:0], 3'b000} +: 8] =
              st_b.acc_at[{st_b.pos[1:0], 3'b000} +: 8] | b;
          end else if (st_b.pos < 4'd8) begin
            st_w.acc_mt[{st_b.pos[1:0], 3'b000} +: 8] =
              st_b.acc_mt[{st_b.pos[1:0], 3'b000} +: 8] | b;
          end else if (st_b.pos < 4'd10) begin
            st_w.acc_uid[{st_b.pos[0], 3'b000} +: 8] =
              st_b.acc_uid[{st_b.pos[0], 3'b000} +: 8] | b;
          end else if (st_b.pos < OLD_LEN) begin
            st_w.acc_gid[{st_b.pos[0], 3'b000} +: 8] =
              st_b.acc_gid[{st_b.pos[0], 3'b000} +: 8] | b;
          end
        end
        zup_pkg::KIND_SECOND: begin
          if (st_b.pos < 4'd2) begin
            st_w.acc_uid[{st_b.pos[0], 3'b000} +: 8] =
              st_b.acc_uid[{st_b.pos[0], 3'b000} +: 8] | b;
          end else if (st_b.pos < SECOND_LEN) begin
            st_w.acc_gid[{st_b.pos[0], 3'b000} +: 8] =
              st_b.acc_gid[{st_b.pos[0], 3'b000} +: 8] | b;
          end
        end
        zup_pkg::KIND_NEW: begin
          case (st_b.phase)
            PH_VERSION: begin
              if (b != NEW_VERSION) begin
                st_w.err   = zup_pkg::ST_VERSION;
                st_w.phase = PH_STOP;
              end else begin
                st_w.phase = PH_ULEN;
              end
            end
            PH_ULEN, PH_GLEN: begin
              st_w.id_len = b;
              st_w.id_cnt = '0;
              if (st_b.phase == PH_ULEN) begin
                st_w.phase = (b == 8'd0) ? PH_GLEN : PH_UBYTES;
              end else begin
                st_w.phase = (b == 8'd0) ? PH_DONE : PH_GBYTES;
              end
            end
            PH_UBYTES, PH_GBYTES: begin
              if (st_b.id_cnt >= 8'(ID_BYTES) && b != 8'd0) begin
                st_w.err = zup_pkg::ST_OVERFLOW;
              end
              if (st_b.id_cnt < 8'd4) begin
                if (st_b.phase == PH_UBYTES) begin
                  st_w.acc_uid[{st_b.id_cnt[1:0], 3'b000} +: 8] =
                    st_b.acc_uid[{st_b.id_cnt[1:0], 3'b000} +: 8] | b;
                end else begin
                  st_w.acc_gid[{st_b.id_cnt[1:0], 3'b000} +: 8] =
                    st_b.acc_gid[{st_b.id_cnt[1:0], 3'b000} +: 8] | b;
                end
              end
              st_w.id_cnt = st_b.id_cnt + 8'd1;
              if (st_w.id_cnt == st_b.id_len) begin
                if (st_w.err != zup_pkg::ST_OK) begin
                  st_w.phase = PH_STOP;
                end else begin
                  st_w.phase = (st_b.phase == PH_UBYTES) ? PH_GLEN : PH_DONE;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      // position only matters up to the old-format length
      if (st_b.pos != OLD_LEN) begin
        st_w.pos = st_b.pos + 4'd1;
      end
    end
  end

  // record status at its last byte
  always_comb begin
    case (st_w.kind)
      zup_pkg::KIND_OLD: begin
        status_w = (st_w.pos >= OLD_LEN) ? zup_pkg::ST_OK : zup_pkg::ST_SHORT;
      end
      zup_pkg::KIND_SECOND: begin
        status_w = (st_w.pos >= SECOND_LEN) ? zup_pkg::ST_OK : zup_pkg::ST_SHORT;
      end
      zup_pkg::KIND_NEW: begin
        if (st_w.phase == PH_DONE) begin
          status_w = zup_pkg::ST_OK;
        end else if (st_w.phase == PH_STOP) begin
          status_w = st_w.err;
        end else begin
          status_w = zup_pkg::ST_SHORT;
        end
      end
      default: begin
        status_w = zup_pkg::ST_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    if (pop) begin
      st_nxt = head.last_item ? parse_t'('0) : st_w;
    end
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r    <= status_w;
      has_times_r <= (status_w == zup_pkg::ST_OK) && (st_w.kind == zup_pkg::KIND_OLD);
      if (status_w == zup_pkg::ST_OK && st_w.kind == zup_pkg::KIND_OLD) begin
        at_r <= st_w.acc_at;
        mt_r <= st_w.acc_mt;
      end else begin
        at_r <= '0;
        mt_r <= '0;
      end
      if (status_w == zup_pkg::ST_OK) begin
        uid_r <= st_w.acc_uid;
        gid_r <= st_w.acc_gid;
      end else begin
        uid_r <= '0;
        gid_r <= '0;
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = status_r;
  assign out_bus.has_times   = has_times_r;
  assign out_bus.access_time = at_r;
  assign out_bus.modify_time = mt_r;
  assign out_bus.user_id     = uid_r;
  assign out_bus.group_id    = gid_r;

  `ZUP_ASSERT_NXT(a_last_result, done, out_valid_r, "last byte gave no result")
  `ZUP_ASSERT_IMP(a_times_ok, out_valid_r && has_times_r, status_r == zup_pkg::ST_OK,
    "times flagged on a failed record")
  `ZUP_ASSERT_IMP(a_err_zero, out_valid_r && status_r != zup_pkg::ST_OK,
    uid_r == '0 && gid_r == '0 && at_r == '0 && mt_r == '0,
    "nonzero fields on a failed record")

endmodule

`default_nettype wire

/* src/zip_unix_extra_field_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   transaction
// in_bus    in    one extra field payload byte, header id, record framing
// out_bus   out   one decoded record: status, times, user and group id
//
// one byte per cycle unless out_bus stalls; the back end retires one queued byte a cycle
// the last byte is registered in the queue before its result is registered for out_bus
// rst_n is synchronous, active low, and empties the queue and the record state
// an output stall holds the result register and the next last byte at the queue head;
// bytes behind it fill the queue until QUEUE_DEPTH entries wait, then in_bus.ready drops

module zip_unix_extra_field_parser #(
  parameter int QUEUE_DEPTH = zup_pkg::QUEUE_DEPTH,
  parameter int ID_BYTES    = zup_pkg::ID_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  zup_in_if.sink     in_bus,
  zup_out_if.source  out_bus
);

  logic            push, q_full, pop, head_valid;
  zup_pkg::entry_t push_ent, head;

  zup_front u_front (
    .in_bus   (in_bus),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  zup_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ent   (push_ent),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  zup_back #(
    .ID_BYTES (ID_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

`default_nettype wire
